// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define CHK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== design/igs_pkg.sv =====
package igs_pkg;

	// Channel count and field widths
	localparam int CHANNELS = 3;
	localparam int PIX_W    = 8;
	localparam int LV_W     = 9;
	localparam int BIN_W    = 9;
	localparam int SUM_W    = 9;

	// Reciprocal of the bin: ceil(2^FRAC_W / bin), exact for sums below 512
	localparam int FRAC_W   = 18;
	localparam int RECIP_W  = FRAC_W + 1;
	localparam int PROD_W   = SUM_W + RECIP_W;

	// Uniform mode scales by levels / 256
	localparam int SCALE_SH = 8;

	localparam logic [LV_W-1:0]    FULL_SCALE = LV_W'(256);
	localparam logic [RECIP_W-1:0] RECIP_ONE  = RECIP_W'(1) << FRAC_W;

	// Configuration register indexes
	localparam logic CFG_MODE   = 1'b0;
	localparam logic CFG_LEVELS = 1'b1;

	typedef struct packed {
		logic             start_of_image;
		logic [PIX_W-1:0] pixel_ch0;
		logic [PIX_W-1:0] pixel_ch1;
		logic [PIX_W-1:0] pixel_ch2;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_ch0;
		logic [PIX_W-1:0] out_ch1;
		logic [PIX_W-1:0] out_ch2;
	} pix_out_t;

	// Step strobes from the sequencer to every lane
	typedef struct packed {
		logic load;
		logic mul;
		logic qb;
		logic fin;
		logic sof;
		logic igs;
	} lane_ctl_t;

	// Divider request and status
	typedef struct packed {
		logic               start;
		logic [RECIP_W-1:0] num;
		logic [BIN_W-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== design/rgb_pixel_quantizer_igs.sv =====
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------
// pixel     | pixel_valid / pixel_ready | pixel (pix_in_t)
// quant     | quant_valid / quant_ready | quant (pix_out_t)
// cfg       | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A pixel: sum, multiply by reciprocal (levels if uniform), quotient times
// bin, then remainder update and output load; the next is taken after that.
// A levels write runs the shared serial divider twice (bin, then reciprocal),
// 19 steps each, with pixel_ready and cfg_ready low.
// Reset: mode uniform, levels 256, remainders zero, output empty.
// A stalled output holds the last lane stage until it can be loaded.
module rgb_pixel_quantizer_igs
	import igs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pixel_valid,
	output logic            pixel_ready,
	input  pix_in_t         pixel,
	output logic            quant_valid,
	input  logic            quant_ready,
	output pix_out_t        quant,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_index,
	input  logic [LV_W-1:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_QB   = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam logic [1:0] CAL_IDLE  = 2'd0;
	localparam logic [1:0] CAL_BIN   = 2'd1;
	localparam logic [1:0] CAL_RECIP = 2'd2;

	logic [1:0]         state_q;
	logic [1:0]         cal_q;
	logic               mode_q;
	logic [LV_W-1:0]    lv_q;
	logic [BIN_W-1:0]   bin_q;
	logic [RECIP_W-1:0] recip_q;
	logic               out_valid_q;
	pix_out_t           out_q;

	logic               accept;
	logic               fin;
	logic               lv_wr;
	logic [LV_W-1:0]    lv_clamp;
	lane_ctl_t          ctl;
	div_req_t           div_req;
	div_stat_t          div_stat;
	logic [RECIP_W-1:0] div_quot;
	logic [PIX_W-1:0]   pix_v [CHANNELS];
	logic [PIX_W-1:0]   q_v   [CHANNELS];

	// Handshakes
	assign pixel_ready = (state_q == ST_IDLE) && (cal_q == CAL_IDLE);
	assign cfg_ready   = (cal_q == CAL_IDLE);
	assign accept      = pixel_valid && pixel_ready;
	assign fin         = (state_q == ST_FIN) && (!out_valid_q || quant_ready);
	assign lv_wr       = cfg_valid && cfg_ready && (cfg_index == CFG_LEVELS);

	// Levels held within 1..256
	always_comb begin
		if (cfg_data == '0) begin
			lv_clamp = LV_W'(1);
		end else if (cfg_data > FULL_SCALE) begin
			lv_clamp = FULL_SCALE;
		end else begin
			lv_clamp = cfg_data;
		end
	end

	// Per-item sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_MUL;
				end
				ST_MUL:  state_q <= ST_QB;
				ST_QB:   state_q <= ST_FIN;
				ST_FIN: begin
					if (fin) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.load = accept;
		ctl.mul  = (state_q == ST_MUL);
		ctl.qb   = (state_q == ST_QB);
		ctl.fin  = fin;
		ctl.sof  = pixel.start_of_image;
		ctl.igs  = mode_q;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			lv_q   <= FULL_SCALE;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MODE) begin
				mode_q <= cfg_data[0];
			end
			if (cfg_index == CFG_LEVELS) begin
				lv_q <= lv_clamp;
			end
		end
	end

	// Bin and reciprocal calculation after a levels write
	always_comb begin
		div_req.start = lv_wr || ((cal_q == CAL_BIN) && div_stat.done);
		if (cal_q == CAL_IDLE) begin
			div_req.num = RECIP_W'(FULL_SCALE);
			div_req.den = lv_clamp;
		end else begin
			div_req.num = RECIP_ONE + RECIP_W'(div_quot[BIN_W-1:0]) - RECIP_W'(1);
			div_req.den = div_quot[BIN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q   <= CAL_IDLE;
			bin_q   <= BIN_W'(1);
			recip_q <= RECIP_ONE;
		end else begin
			case (cal_q)
				CAL_IDLE: begin
					if (lv_wr) cal_q <= CAL_BIN;
				end
				CAL_BIN: begin
					if (div_stat.done) begin
						bin_q <= div_quot[BIN_W-1:0];
						cal_q <= CAL_RECIP;
					end
				end
				CAL_RECIP: begin
					if (div_stat.done) begin
						recip_q <= div_quot;
						cal_q   <= CAL_IDLE;
					end
				end
				default: cal_q <= CAL_IDLE;
			endcase
		end
	end

	igs_div #(
		.NUM_W(RECIP_W),
		.DEN_W(BIN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_req.start),
		.num    (div_req.num),
		.den    (div_req.den),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	// Channel lanes
	assign pix_v[0] = pixel.pixel_ch0;
	assign pix_v[1] = pixel.pixel_ch1;
	assign pix_v[2] = pixel.pixel_ch2;

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		igs_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.pixel  (pix_v[c]),
			.lv     (lv_q),
			.bin    (bin_q),
			.recip  (recip_q),
			.q      (q_v[c])
		);
	end

	// Merge lane results into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (quant_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_q.out_ch0 <= q_v[0];
			out_q.out_ch1 <= q_v[1];
			out_q.out_ch2 <= q_v[2];
		end
	end

	assign quant_valid = out_valid_q;
	assign quant       = out_q;

endmodule

// ===== design/igs_div.sv =====
module igs_div
	import igs_pkg::*;
#(
	parameter int NUM_W = RECIP_W,
	parameter int DEN_W = BIN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output div_stat_t        stat,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	// One restoring step: bring down the next numerator bit
	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = (shifted >= {1'b0, den_q});
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits shift in as numerator bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quo_q;

endmodule

// ===== design/igs_lane.sv =====
module igs_lane
	import igs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctl_t          ctl,
	input  logic [PIX_W-1:0]   pixel,
	input  logic [LV_W-1:0]    lv,
	input  logic [BIN_W-1:0]   bin,
	input  logic [RECIP_W-1:0] recip,
	output logic [PIX_W-1:0]   q
);

	logic [PIX_W-1:0]   rem_q;
	logic [SUM_W-1:0]   op_s1;
	logic [PROD_W-1:0]  prod_s2;
	logic [PIX_W-1:0]   q_s3;
	logic [SUM_W-1:0]   qb_s3;

	logic [SUM_W-1:0]   sum;
	logic [RECIP_W-1:0] mul_b;
	logic [PIX_W-1:0]   q_next;
	logic [16:0]        qb_full;
	logic [SUM_W-1:0]   rem_next;

	// Sample plus carried remainder; start of image drops the carry
	always_comb begin
		sum = {1'b0, pixel} + (ctl.sof ? SUM_W'(0) : SUM_W'(rem_q));
	end

	// Multiplier operand: reciprocal of the bin, or the level count
	always_comb begin
		mul_b = ctl.igs ? recip : RECIP_W'(lv);
	end

	// Quotient out of the product, then quotient times bin
	always_comb begin
		if (ctl.igs) begin
			q_next = prod_s2[FRAC_W +: PIX_W];
		end else begin
			q_next = prod_s2[SCALE_SH +: PIX_W];
		end
		qb_full  = 17'(q_next) * 17'(bin);
		rem_next = op_s1 - qb_s3;
	end

	// Stage registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_s1 <= ctl.igs ? sum : {1'b0, pixel};
		end
		if (ctl.mul) begin
			prod_s2 <= PROD_W'(op_s1) * PROD_W'(mul_b);
		end
		if (ctl.qb) begin
			q_s3  <= q_next;
			qb_s3 <= qb_full[SUM_W-1:0];
		end
	end

	// Carried remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctl.load && ctl.sof) begin
			rem_q <= '0;
		end else if (ctl.fin && ctl.igs) begin
			rem_q <= rem_next[PIX_W-1:0];
		end
	end

	assign q = q_s3;

endmodule

// ===== design/igs_chk.sv =====
`include "assert_macros.svh"

module igs_chk
	import igs_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            pixel_valid,
	input logic            pixel_ready,
	input logic            quant_valid,
	input logic            quant_ready,
	input pix_out_t        quant,
	input logic            cfg_valid,
	input logic            cfg_ready,
	input logic            cfg_index
);

	// A held result keeps its value until taken
	`CHK_NEXT(a_out_hold, quant_valid && !quant_ready, quant_valid && $stable(quant), "result changed while stalled")

	// One item at a time: a taken pixel closes the input
	`CHK_NEXT(a_one_item, pixel_valid && pixel_ready, !pixel_ready, "pixel taken while busy")

	// A new result only comes out of a busy cycle
	`CHK_IMPL(a_no_invent, $rose(quant_valid), !$past(pixel_ready), "result without work in flight")

	// A levels write starts the bin calculation
	`CHK_NEXT(a_lv_cal, cfg_valid && cfg_ready && (cfg_index == CFG_LEVELS), !cfg_ready && !pixel_ready, "levels write did not recalc bin")

endmodule

bind rgb_pixel_quantizer_igs igs_chk u_chk (.*);
